>>> hdl/rlfh_pkg.sv
// ---------------------------------------------------------------------------
// rlfh_pkg : shared types and constants of the recursive lock manager
// Request and response payloads, command and status codes, queue geometry
// and the circular queue pointer helper.
// ---------------------------------------------------------------------------
`default_nettype none

package rlfh_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 8;
   localparam int COUNT_BITS  = 16;

   localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   // fixed widths of the response fields
   localparam int STATUS_W    = 4;
   localparam int REC_W       = 16;
   localparam int WAIT_W      = 5;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      CMD_ENTER     = 2'd0,
      CMD_TRY_ENTER = 2'd1,
      CMD_LEAVE     = 2'd2,
      CMD_CANCEL    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ACQUIRED     = 4'd0,
      ST_RECURSIVE    = 4'd1,
      ST_QUEUED       = 4'd2,
      ST_BUSY         = 4'd3,
      ST_STILL_HELD   = 4'd4,
      ST_FREED        = 4'd5,
      ST_HANDED_OFF   = 4'd6,
      ST_NOT_OWNER    = 4'd7,
      ST_QUEUE_FULL   = 4'd8,
      ST_CANCELLED    = 4'd9,
      ST_NOT_WAITING  = 4'd10,
      ST_REC_OVERFLOW = 4'd11
   } status_type;

   typedef struct packed {
      cmd_type             command;
      logic [ID_BITS-1:0]  requester_id;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic                grant_valid;
      logic [ID_BITS-1:0]  granted_id;
      logic                owner_valid;
      logic [ID_BITS-1:0]  owner_id;
      logic [REC_W-1:0]    recursion_count;
      logic [WAIT_W-1:0]   waiter_count;
   } rsp_type;

   // finished response from the controller towards the output stage
   typedef struct packed {
      logic     valid;
      rsp_type  data;
   } result_type;

   // one write port and one read port of the wait queue memory
   typedef struct packed {
      logic                we;
      logic [PTR_BITS-1:0] waddr;
      logic [ID_BITS-1:0]  wdata;
      logic                re;
      logic [PTR_BITS-1:0] raddr;
   } mem_req_type;

   // address of queue position off, counted from the head, wrapping at the depth
   function automatic logic [PTR_BITS-1:0] queue_ptr_add(
      input logic [PTR_BITS-1:0] base,
      input logic [CNT_BITS-1:0] off
   );
      logic [CNT_BITS+PTR_BITS:0] sum;
      sum = (CNT_BITS+PTR_BITS+1)'(base) + (CNT_BITS+PTR_BITS+1)'(off);
      if (sum >= (CNT_BITS+PTR_BITS+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_BITS+PTR_BITS+1)'(QUEUE_DEPTH);
      end
      return PTR_BITS'(sum);
   endfunction

endpackage

`default_nettype wire

>>> hdl/rlfh_ram.sv
// ---------------------------------------------------------------------------
// rlfh_ram : simple dual port synchronous RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module rlfh_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8,
   parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [ABITS-1:0] waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [ABITS-1:0] raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hdl/rlfh_ctrl.sv
// ---------------------------------------------------------------------------
// rlfh_ctrl : lock state and wait queue sequencer
// Holds owner, nesting and the circular queue pointers, drives the queue
// memory for enqueue, handoff, cancel search and compaction.
// ---------------------------------------------------------------------------
`default_nettype none

module rlfh_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire rlfh_pkg::req_type            req_payload,
   input  wire logic                         out_free,
   output rlfh_pkg::result_type              result,
   output rlfh_pkg::mem_req_type             mem,
   input  wire logic [rlfh_pkg::ID_BITS-1:0] rd_data
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_SHIFT = 5'b00100,
      S_GRANT = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type                             state_ff, state_in;
   logic                                  held_ff, held_in;
   logic [rlfh_pkg::ID_BITS-1:0]          owner_ff, owner_in;
   logic [rlfh_pkg::COUNT_BITS-1:0]       nest_ff, nest_in;
   logic [rlfh_pkg::PTR_BITS-1:0]         head_ff, head_in;
   logic [rlfh_pkg::CNT_BITS-1:0]         len_ff, len_in;
   logic [rlfh_pkg::CNT_BITS-1:0]         idx_ff, idx_in;
   logic [rlfh_pkg::ID_BITS-1:0]          id_ff, id_in;
   rlfh_pkg::status_type                  status_ff, status_in;
   logic                                  gval_ff, gval_in;
   logic [rlfh_pkg::ID_BITS-1:0]          gid_ff, gid_in;

   logic [rlfh_pkg::CNT_BITS:0]           idx_p1;
   logic [rlfh_pkg::CNT_BITS:0]           idx_p2;

   assign idx_p1 = (rlfh_pkg::CNT_BITS+1)'(idx_ff) + (rlfh_pkg::CNT_BITS+1)'(1);
   assign idx_p2 = (rlfh_pkg::CNT_BITS+1)'(idx_ff) + (rlfh_pkg::CNT_BITS+1)'(2);

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      held_in   = held_ff;
      owner_in  = owner_ff;
      nest_in   = nest_ff;
      head_in   = head_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      id_in     = id_ff;
      status_in = status_ff;
      gval_in   = gval_ff;
      gid_in    = gid_ff;
      mem       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               gval_in  = 1'b0;
               gid_in   = '0;
               id_in    = req_payload.requester_id;
               state_in = S_DONE;
               unique case (req_payload.command)
                  rlfh_pkg::CMD_ENTER, rlfh_pkg::CMD_TRY_ENTER: begin
                     if (!held_ff) begin
                        held_in   = 1'b1;
                        owner_in  = req_payload.requester_id;
                        nest_in   = rlfh_pkg::COUNT_BITS'(1);
                        status_in = rlfh_pkg::ST_ACQUIRED;
                     end else if (owner_ff == req_payload.requester_id) begin
                        if (nest_ff == rlfh_pkg::COUNT_MAX) begin
                           status_in = rlfh_pkg::ST_REC_OVERFLOW;
                        end else begin
                           nest_in   = nest_ff + rlfh_pkg::COUNT_BITS'(1);
                           status_in = rlfh_pkg::ST_RECURSIVE;
                        end
                     end else if (req_payload.command == rlfh_pkg::CMD_TRY_ENTER) begin
                        status_in = rlfh_pkg::ST_BUSY;
                     end else if (len_ff == rlfh_pkg::CNT_BITS'(rlfh_pkg::QUEUE_DEPTH)) begin
                        status_in = rlfh_pkg::ST_QUEUE_FULL;
                     end else begin
                        mem.we    = 1'b1;
                        mem.waddr = rlfh_pkg::queue_ptr_add(head_ff, len_ff);
                        mem.wdata = req_payload.requester_id;
                        len_in    = len_ff + rlfh_pkg::CNT_BITS'(1);
                        status_in = rlfh_pkg::ST_QUEUED;
                     end
                  end
                  rlfh_pkg::CMD_LEAVE: begin
                     if (!held_ff || owner_ff != req_payload.requester_id
                         || nest_ff == '0) begin
                        status_in = rlfh_pkg::ST_NOT_OWNER;
                     end else if (nest_ff != rlfh_pkg::COUNT_BITS'(1)) begin
                        nest_in   = nest_ff - rlfh_pkg::COUNT_BITS'(1);
                        status_in = rlfh_pkg::ST_STILL_HELD;
                     end else if (len_ff != '0) begin
                        // fetch the oldest waiter, finish the handoff next cycle
                        mem.re    = 1'b1;
                        mem.raddr = head_ff;
                        state_in  = S_GRANT;
                     end else begin
                        held_in   = 1'b0;
                        owner_in  = '0;
                        nest_in   = '0;
                        status_in = rlfh_pkg::ST_FREED;
                     end
                  end
                  rlfh_pkg::CMD_CANCEL: begin
                     if (len_ff == '0) begin
                        status_in = rlfh_pkg::ST_NOT_WAITING;
                     end else begin
                        mem.re    = 1'b1;
                        mem.raddr = head_ff;
                        idx_in    = '0;
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                     status_in = rlfh_pkg::ST_NOT_WAITING;
                  end
               endcase
            end
         end

         S_GRANT: begin
            held_in   = 1'b1;
            owner_in  = rd_data;
            nest_in   = rlfh_pkg::COUNT_BITS'(1);
            head_in   = rlfh_pkg::queue_ptr_add(head_ff, rlfh_pkg::CNT_BITS'(1));
            len_in    = len_ff - rlfh_pkg::CNT_BITS'(1);
            gval_in   = 1'b1;
            gid_in    = rd_data;
            status_in = rlfh_pkg::ST_HANDED_OFF;
            state_in  = S_DONE;
         end

         S_SCAN: begin
            // rd_data holds queue position idx
            if (rd_data == id_ff) begin
               if (idx_p1 < (rlfh_pkg::CNT_BITS+1)'(len_ff)) begin
                  mem.re    = 1'b1;
                  mem.raddr = rlfh_pkg::queue_ptr_add(head_ff,
                                                      rlfh_pkg::CNT_BITS'(idx_p1));
                  state_in  = S_SHIFT;
               end else begin
                  len_in    = len_ff - rlfh_pkg::CNT_BITS'(1);
                  status_in = rlfh_pkg::ST_CANCELLED;
                  state_in  = S_DONE;
               end
            end else if (idx_p1 < (rlfh_pkg::CNT_BITS+1)'(len_ff)) begin
               mem.re    = 1'b1;
               mem.raddr = rlfh_pkg::queue_ptr_add(head_ff, rlfh_pkg::CNT_BITS'(idx_p1));
               idx_in    = rlfh_pkg::CNT_BITS'(idx_p1);
            end else begin
               status_in = rlfh_pkg::ST_NOT_WAITING;
               state_in  = S_DONE;
            end
         end

         S_SHIFT: begin
            // rd_data holds position idx+1: move it down to idx; the read
            // always runs two positions ahead of the write, so no overlap
            mem.we    = 1'b1;
            mem.waddr = rlfh_pkg::queue_ptr_add(head_ff, idx_ff);
            mem.wdata = rd_data;
            if (idx_p2 < (rlfh_pkg::CNT_BITS+1)'(len_ff)) begin
               mem.re    = 1'b1;
               mem.raddr = rlfh_pkg::queue_ptr_add(head_ff, rlfh_pkg::CNT_BITS'(idx_p2));
               idx_in    = rlfh_pkg::CNT_BITS'(idx_p1);
            end else begin
               len_in    = len_ff - rlfh_pkg::CNT_BITS'(1);
               status_in = rlfh_pkg::ST_CANCELLED;
               state_in  = S_DONE;
            end
         end

         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      result.valid                = (state_ff == S_DONE);
      result.data.status          = status_ff;
      result.data.grant_valid     = gval_ff;
      result.data.granted_id      = gid_ff;
      result.data.owner_valid     = held_ff;
      result.data.owner_id        = held_ff ? owner_ff : '0;
      result.data.recursion_count = rlfh_pkg::REC_W'(nest_ff);
      result.data.waiter_count    = rlfh_pkg::WAIT_W'(len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         held_ff  <= 1'b0;
         owner_ff <= '0;
         nest_ff  <= '0;
         head_ff  <= '0;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         owner_ff <= owner_in;
         nest_ff  <= nest_in;
         head_ff  <= head_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      id_ff     <= id_in;
      status_ff <= status_in;
      gval_ff   <= gval_in;
      gid_ff    <= gid_in;
   end

endmodule

`default_nettype wire

>>> hdl/recursive_lock_fifo_handoff.sv
// ---------------------------------------------------------------------------
// recursive_lock_fifo_handoff : recursive lock with FIFO handoff to waiters
// Owner, nesting count and a circular wait queue held in a small RAM; the
// last nested leave passes ownership straight to the oldest waiter.
// ---------------------------------------------------------------------------
//
//   channel | ports                              | moves
//   --------+------------------------------------+------------------------------
//   req     | req_valid, req_ready, req_payload  | one request: command, id
//   rsp     | rsp_valid, rsp_ready, rsp_payload  | one response per request
//
// From accept to response register: enter, try-enter and leave pass straight
// to the completion stage; a leave that hands off first does one RAM read of
// the queue head; a cancel with waiters queued first searches and compacts,
// walking the queue RAM one position per cycle. One request is in work at a
// time; a new one is taken while the previous response waits in the output
// register. Synchronous reset frees the lock and empties the queue at once;
// the queue RAM itself is not cleared, only live positions are ever read.
// A stalled response holds its request's completion stage until taken.
// ---------------------------------------------------------------------------
`default_nettype none

module recursive_lock_fifo_handoff (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rlfh_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rlfh_pkg::rsp_type      rsp_payload
);

   rlfh_pkg::result_type             result;
   rlfh_pkg::mem_req_type            mem;
   logic [rlfh_pkg::ID_BITS-1:0]     rd_data;
   logic                             out_free;

   logic                             rsp_valid_ff, rsp_valid_in;
   rlfh_pkg::rsp_type                rsp_payload_ff;

   // Sequencer: lock state, queue pointers and the RAM access pattern
   rlfh_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .out_free    (out_free),
      .result      (result),
      .mem         (mem),
      .rd_data     (rd_data)
   );

   // Wait queue storage, one id per position
   rlfh_ram #(
      .DEPTH (rlfh_pkg::QUEUE_DEPTH),
      .WIDTH (rlfh_pkg::ID_BITS),
      .ABITS (rlfh_pkg::PTR_BITS)
   ) u_queue_ram (
      .clock (clock),
      .we    (mem.we),
      .waddr (mem.waddr),
      .wdata (mem.wdata),
      .re    (mem.re),
      .raddr (mem.raddr),
      .rdata (rd_data)
   );

   // Output register: free when empty or being drained this cycle
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = (result.valid && out_free) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the payload only when a finished response moves in
   always_ff @(posedge clock) begin
      if (result.valid && out_free) begin
         rsp_payload_ff <= result.data;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A handoff leaves the granted waiter as owner at nesting one
   a_handoff_owner : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.grant_valid) |->
         (rsp_payload.owner_valid && rsp_payload.owner_id == rsp_payload.granted_id
          && rsp_payload.recursion_count == rlfh_pkg::REC_W'(1)
          && rsp_payload.status == rlfh_pkg::ST_HANDED_OFF))
      else $error("handoff response without matching owner");

   // A free lock reports no owner and no nesting
   a_free_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.owner_valid) |->
         (rsp_payload.owner_id == '0 && rsp_payload.recursion_count == '0))
      else $error("free lock with stale owner or nesting");

   // A finished response that cannot move is held by the sequencer
   a_result_hold : assert property (@(posedge clock) disable iff (reset)
      (result.valid && !out_free) |=> (result.valid && !req_ready))
      else $error("finished response dropped while output stalled");

   // No new request is taken while a response is still being built
   a_one_in_work : assert property (@(posedge clock) disable iff (reset)
      result.valid |-> !req_ready)
      else $error("request accepted during completion");

endmodule

`default_nettype wire
